[design/identify_effect_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// identify effect sequencer assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef IDENTIFY_EFFECT_SEQUENCER_DEFINES_SVH
`define IDENTIFY_EFFECT_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent holds in a cycle, consequent holds in the same cycle
`define IES_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle, consequent holds in the next cycle
`define IES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IES_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define IES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/ies_pkg.sv]
// ----------------------------------------------------------------------------
// ies_pkg
// types and constants shared by the identify effect sequencer files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ies_pkg;

    // request types
    localparam logic [2:0] REQ_TICK        = 3'd0;
    localparam logic [2:0] REQ_EFFECT      = 3'd1;
    localparam logic [2:0] REQ_ID_CHECK    = 3'd2;
    localparam logic [2:0] REQ_TIME_WRITE  = 3'd3;
    localparam logic [2:0] REQ_APPLY_STATE = 3'd4;

    // effect command codes
    localparam logic [7:0] EFFECT_BLINK   = 8'd0;
    localparam logic [7:0] EFFECT_BREATHE = 8'd1;
    localparam logic [7:0] EFFECT_OKAY    = 8'd2;
    localparam logic [7:0] EFFECT_CHANNEL = 8'd11;
    localparam logic [7:0] EFFECT_FINISH  = 8'd254;
    localparam logic [7:0] EFFECT_STOP    = 8'd255;

    // levels and tick budgets
    localparam logic [7:0] LEVEL_MAX      = 8'd254;
    localparam logic [7:0] LEVEL_BLINK_ON = 8'd250;
    localparam logic [7:0] BREATHE_TOP    = 8'd250;
    localparam logic [7:0] BREATHE_STEP   = 8'd50;
    localparam logic [7:0] BREATHE_COUNT  = 8'd15;
    localparam logic [7:0] BLINK_TICKS    = 8'd10;
    localparam logic [7:0] BREATHE_TICKS  = 8'd200;
    localparam logic [7:0] OKAY_TICKS     = 8'd15;
    localparam logic [7:0] CHANNEL_TICKS  = 8'd80;
    localparam logic [7:0] OKAY_FLIP_A    = 8'd10;
    localparam logic [7:0] OKAY_FLIP_B    = 8'd5;
    localparam logic [7:0] CHANNEL_DIM_AT = 8'd74;
    localparam logic [7:0] CHANNEL_DIM    = 8'd1;
    localparam logic [7:0] IDENT_PERIOD   = 8'd5;

    // identify time loaded by each effect
    localparam logic [15:0] BLINK_TIME   = 16'd2;
    localparam logic [15:0] BREATHE_TIME = 16'd17;
    localparam logic [15:0] OKAY_TIME    = 16'd3;
    localparam logic [15:0] CHANNEL_TIME = 16'd9;
    localparam logic [15:0] STOP_TIME    = 16'd1;

    typedef enum logic [4:0] {
        KIND_BLINK   = 5'b00001,
        KIND_BREATHE = 5'b00010,
        KIND_OKAY    = 5'b00100,
        KIND_CHANNEL = 5'b01000,
        KIND_STOP    = 5'b10000
    } effect_kind_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  effect_code;
        logic [15:0] identify_time_value;
        logic        on_off;
        logic [7:0]  current_level;
    } req_word_t;

    typedef struct packed {
        logic       bulb_update;
        logic       bulb_on;
        logic [7:0] bulb_level;
        logic       identifying;
        logic       effect_running;
    } rsp_word_t;

endpackage

[design/ies_req_if.sv]
// ----------------------------------------------------------------------------
// ies_req_if
// event channel into the identify effect sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ies_req_if;

    logic              valid;
    logic              ready;
    ies_pkg::req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[design/ies_rsp_if.sv]
// ----------------------------------------------------------------------------
// ies_rsp_if
// bulb command and status channel out of the identify effect sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ies_rsp_if;

    logic              valid;
    logic              ready;
    ies_pkg::rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[design/identify_effect_sequencer.sv]
// ----------------------------------------------------------------------------
// identify_effect_sequencer
// sequences identify effects of a dimmable light and issues bulb commands
// ----------------------------------------------------------------------------
// usage:
//   req carries one event word per handshake: tick, effect command, identify
//   check, identify time write or apply current state, together with the live
//   on/off and level of the light.
//   rsp returns exactly one word per event: the bulb command (if any) and the
//   identifying / effect running flags after the event.
//   path: a word accepted on req lands in the input register, and its result
//   loads into the result register once that register is empty or being read
//   by rsp, which hands the word on from there.
//   throughput: one word per cycle while rsp is not held off; the effect state
//   is updated in the same cycle that the result register loads, so consecutive
//   words see each other's state without waiting.
//   stall: while rsp is held off, the result register holds its word and the
//   input register holds the next one; req.ready drops only when both are full.
//   reset: effect stopped, identify time zero, all counters zero, both
//   registers empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "identify_effect_sequencer_defines.svh"

module identify_effect_sequencer (
    input  logic  clk,
    input  logic  rst_n,
    ies_req_if.sink   req,
    ies_rsp_if.source rsp
);

    import ies_pkg::*;

    logic         in_valid_reg;
    req_word_t    req_word_reg;
    logic         rsp_valid_reg;
    rsp_word_t    rsp_word_reg;
    logic         advance;

    effect_kind_t kind_reg, kind_next;
    logic [7:0]   tick_left_reg, tick_left_next;
    logic [7:0]   level_reg, level_next;
    logic [7:0]   step_reg, step_next;
    logic         ramp_up_reg, ramp_up_next;
    logic         finish_reg, finish_next;
    logic [15:0]  id_time_reg, id_time_next;
    logic         id_active_reg, id_active_next;

    logic         cmd_valid;
    logic         cmd_on;
    logic [7:0]   cmd_level;
    rsp_word_t    rsp_word_next;

    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word_reg;

    always_comb
    begin
        kind_next      = kind_reg;
        tick_left_next = tick_left_reg;
        level_next     = level_reg;
        step_next      = step_reg;
        ramp_up_next   = ramp_up_reg;
        finish_next    = finish_reg;
        id_time_next   = id_time_reg;
        id_active_next = id_active_reg;
        cmd_valid      = 1'b0;
        cmd_on         = 1'b0;
        cmd_level      = '0;

        case (req_word_reg.req_type)
            REQ_TICK:
            begin
                if (kind_reg != KIND_STOP)
                begin
                    if (tick_left_reg != 8'd0)
                    begin
                        tick_left_next = tick_left_reg - 8'd1;
                        cmd_valid      = 1'b1;
                        cmd_on         = 1'b1;
                        cmd_level      = level_reg;
                        case (kind_reg)
                            KIND_BREATHE:
                            begin
                                if (ramp_up_reg)
                                begin
                                    if (level_reg >= BREATHE_TOP)
                                    begin
                                        level_next   = level_reg - BREATHE_STEP;
                                        ramp_up_next = 1'b0;
                                    end
                                    else
                                    begin
                                        level_next = level_reg + BREATHE_STEP;
                                    end
                                end
                                else if (level_reg == 8'd0)
                                begin
                                    step_next = step_reg - 8'd1;
                                    if (step_next != 8'd0 && !finish_reg)
                                    begin
                                        level_next   = BREATHE_STEP;
                                        ramp_up_next = 1'b1;
                                    end
                                    else
                                    begin
                                        tick_left_next = '0;
                                    end
                                end
                                else
                                begin
                                    level_next = level_reg - BREATHE_STEP;
                                end
                            end
                            KIND_OKAY:
                            begin
                                if (tick_left_next == OKAY_FLIP_A
                                    || tick_left_next == OKAY_FLIP_B)
                                begin
                                    level_next = level_reg ^ LEVEL_MAX;
                                    if (finish_reg)
                                    begin
                                        tick_left_next = '0;
                                    end
                                end
                            end
                            KIND_CHANNEL:
                            begin
                                if (tick_left_next == CHANNEL_DIM_AT)
                                begin
                                    level_next = CHANNEL_DIM;
                                    if (finish_reg)
                                    begin
                                        tick_left_next = '0;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else
                    begin
                        // budget used up: stop and restore the live state
                        kind_next    = KIND_STOP;
                        ramp_up_next = 1'b0;
                        id_time_next = '0;
                        cmd_valid    = 1'b1;
                        cmd_on       = req_word_reg.on_off;
                        cmd_level    = req_word_reg.on_off ? req_word_reg.current_level : '0;
                    end
                end
                else if (id_time_reg != 16'd0)
                begin
                    // plain identify blink
                    step_next = step_reg - 8'd1;
                    if (step_next == 8'd0)
                    begin
                        step_next = IDENT_PERIOD;
                        cmd_valid = 1'b1;
                        if (level_reg != 8'd0)
                        begin
                            level_next = '0;
                        end
                        else
                        begin
                            level_next = LEVEL_BLINK_ON;
                            cmd_on     = 1'b1;
                            cmd_level  = LEVEL_MAX;
                        end
                    end
                end
            end
            REQ_EFFECT:
            begin
                case (req_word_reg.effect_code)
                    EFFECT_BLINK:
                    begin
                        kind_next      = KIND_BLINK;
                        level_next     = req_word_reg.on_off ? 8'd0 : LEVEL_BLINK_ON;
                        finish_next    = 1'b0;
                        id_time_next   = BLINK_TIME;
                        tick_left_next = BLINK_TICKS;
                    end
                    EFFECT_BREATHE:
                    begin
                        kind_next      = KIND_BREATHE;
                        ramp_up_next   = 1'b1;
                        finish_next    = 1'b0;
                        level_next     = '0;
                        step_next      = BREATHE_COUNT;
                        id_time_next   = BREATHE_TIME;
                        tick_left_next = BREATHE_TICKS;
                    end
                    EFFECT_OKAY:
                    begin
                        kind_next      = KIND_OKAY;
                        finish_next    = 1'b0;
                        level_next     = req_word_reg.on_off ? 8'd0 : LEVEL_MAX;
                        id_time_next   = OKAY_TIME;
                        tick_left_next = OKAY_TICKS;
                    end
                    EFFECT_CHANNEL:
                    begin
                        kind_next      = KIND_CHANNEL;
                        level_next     = LEVEL_MAX;
                        finish_next    = 1'b0;
                        id_time_next   = CHANNEL_TIME;
                        tick_left_next = CHANNEL_TICKS;
                    end
                    EFFECT_FINISH:
                    begin
                        if (kind_reg != KIND_STOP)
                        begin
                            finish_next = 1'b1;
                        end
                    end
                    EFFECT_STOP:
                    begin
                        kind_next    = KIND_STOP;
                        id_time_next = STOP_TIME;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_ID_CHECK:
            begin
                if (kind_reg == KIND_STOP)
                begin
                    if (id_time_reg == 16'd0)
                    begin
                        cmd_valid      = 1'b1;
                        cmd_on         = req_word_reg.on_off;
                        cmd_level      = req_word_reg.on_off ? req_word_reg.current_level : '0;
                        id_active_next = 1'b0;
                    end
                    else if (!id_active_reg)
                    begin
                        id_active_next = 1'b1;
                        level_next     = LEVEL_BLINK_ON;
                        step_next      = IDENT_PERIOD;
                        cmd_valid      = 1'b1;
                        cmd_on         = 1'b1;
                        cmd_level      = LEVEL_MAX;
                    end
                end
            end
            REQ_TIME_WRITE:
            begin
                id_time_next = req_word_reg.identify_time_value;
            end
            REQ_APPLY_STATE:
            begin
                cmd_valid = 1'b1;
                cmd_on    = req_word_reg.on_off;
                cmd_level = req_word_reg.on_off ? req_word_reg.current_level : '0;
            end
            default:
            begin
            end
        endcase

        rsp_word_next.bulb_update    = cmd_valid;
        rsp_word_next.bulb_on        = cmd_on;
        rsp_word_next.bulb_level     = cmd_level;
        rsp_word_next.identifying    = (id_time_next != 16'd0);
        rsp_word_next.effect_running = (kind_next != KIND_STOP);
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_word_reg <= req.data;
        end
    end

    // effect state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_STOP;
            tick_left_reg <= '0;
            level_reg     <= '0;
            step_reg      <= '0;
            ramp_up_reg   <= 1'b0;
            finish_reg    <= 1'b0;
            id_time_reg   <= '0;
            id_active_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                kind_reg      <= kind_next;
                tick_left_reg <= tick_left_next;
                level_reg     <= level_next;
                step_reg      <= step_next;
                ramp_up_reg   <= ramp_up_next;
                finish_reg    <= finish_next;
                id_time_reg   <= id_time_next;
                id_active_reg <= id_active_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    `IES_ASSERT_SAME(a_off_means_dark, clk, rst_n, rsp_valid_reg && !rsp_word_reg.bulb_on, rsp_word_reg.bulb_level == 8'd0, "bulb off with nonzero level")
    `IES_ASSERT_SAME(a_no_cmd_no_on, clk, rst_n, rsp_valid_reg && !rsp_word_reg.bulb_update, !rsp_word_reg.bulb_on, "bulb on without a command")
    `IES_ASSERT_SAME(a_running_flag, clk, rst_n, rsp_valid_reg, rsp_word_reg.effect_running == (kind_reg != KIND_STOP), "running flag out of step with effect state")
    `IES_ASSERT_SAME(a_identify_flag, clk, rst_n, rsp_valid_reg, rsp_word_reg.identifying == (id_time_reg != 16'd0), "identifying flag out of step with identify time")
    `IES_ASSERT_NEXT(a_advance_gives_word, clk, rst_n, advance, rsp_valid_reg, "processed word did not reach the result register")

endmodule
